### sv/avld_pkg.sv
package avld_pkg;

    // Longest line kept, terminator excluded, is LINE_CAPACITY-1 characters.
    localparam int LINE_CAPACITY = 64;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);

    localparam int VAL_W   = 16;
    localparam int MAG_W   = 16;
    localparam int ACC_W   = MAG_W + 4;
    localparam int TDATA_W = 2 * VAL_W;
    localparam int TUSER_W = 2;

    // Saturation limits for the field magnitude.
    localparam logic [MAG_W-1:0] MAG_SAT = MAG_W'(32768);
    localparam logic [MAG_W-1:0] POS_MAX = MAG_W'(32767);

    // Input beat kinds, carried on s_tuser.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Characters of interest.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_V     = 8'h56;

    typedef enum logic [6:0] {
        PH_HDR_V   = 7'b0000001,
        PH_HDR_C   = 7'b0000010,
        PH_F1_WS   = 7'b0000100,
        PH_F1_DIG  = 7'b0001000,
        PH_F1_DONE = 7'b0010000,
        PH_F2_WS   = 7'b0100000,
        PH_F2_DIG  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic              line_accepted;
        logic              data_fresh;
        logic [VAL_W-1:0]  green_code;
        logic [VAL_W-1:0]  pixel_error;
    } result_t;

endpackage

### sv/ascii_vision_line_decoder_top.sv
// Each result beat is registered in the output register, or in the skid register on a stall.
// Throughput: one input beat per cycle while the skid register is empty; the parser state
// and the multiply-by-ten accumulate update in the same cycle that a byte is accepted.
// Two result slots (output register plus skid register) let one more input beat be taken
// while the master side stalls.
// Reset (rst_n low, asynchronous) clears the parser, the stored values and the fresh flag.
module ascii_vision_line_decoder_top
    import avld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    input  logic               s_tuser,   // [0] opcode

    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [15:0] pixel_error, [31:16] green_code
    output logic [TUSER_W-1:0] m_tuser    // [0] data_fresh, [1] line_accepted
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_CAPACITY - 1);

    // Parser and published state.
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    phase_t           phase_reg, phase_next;
    logic             neg_reg,   neg_next;
    logic [MAG_W-1:0] mag_reg,   mag_next;
    logic [VAL_W-1:0] first_reg, first_next;
    logic             ended_reg, ended_next;
    logic [VAL_W-1:0] err_reg,   err_next;
    logic [VAL_W-1:0] code_reg,  code_next;
    logic             fresh_reg, fresh_next;

    // Result slots.
    result_t          out_reg,   skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    result_t          res;
    logic             push, pop;
    logic [7:0]       c;
    logic             is_blank, is_digit;
    logic [ACC_W-1:0] mag_prod;
    logic [MAG_W-1:0] mag_digit;
    logic [VAL_W-1:0] field_val;

    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;
    assign c        = s_tdata;

    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
                      (c == CH_LF) || (c == CH_CR);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    // Accumulate one decimal digit, saturating at 32768.
    assign mag_prod  = ACC_W'(mag_reg) * ACC_W'(10) + ACC_W'(c - CH_ZERO);
    assign mag_digit = (mag_prod > ACC_W'(MAG_SAT)) ? MAG_SAT : mag_prod[MAG_W-1:0];

    // Signed value of the field read so far. A negative magnitude never exceeds 32768,
    // so plain two's complement negation lands on -32768 at the limit.
    assign field_val = neg_reg ? VAL_W'(-mag_reg)
                               : ((mag_reg > POS_MAX) ? POS_MAX : mag_reg);

    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        first_next = first_reg;
        ended_next = ended_reg;
        err_next   = err_reg;
        code_next  = code_reg;
        fresh_next = fresh_reg;
        res.line_accepted = 1'b0;

        if (push && (s_tuser == OP_BYTE))
        begin
            if ((c == CH_LF) || (c == CH_CR))
            begin
                // A line end with nothing kept is an empty line and is ignored.
                if (cnt_reg != '0)
                begin
                    if ((phase_reg == PH_F2_WS) || (phase_reg == PH_F2_DIG))
                    begin
                        err_next   = first_reg;
                        code_next  = field_val;
                        fresh_next = 1'b1;
                        res.line_accepted = 1'b1;
                    end
                    cnt_next   = '0;
                    phase_next = PH_HDR_V;
                    ended_next = 1'b0;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                end
            end
            else if (cnt_reg < CNT_MAX)
            begin
                cnt_next = cnt_reg + 1'b1;
                if (!ended_reg)
                begin
                    if (c == CH_NUL)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_HDR_V:
                            begin
                                if (c == CH_V)
                                    phase_next = PH_HDR_C;
                                else
                                    ended_next = 1'b1;
                            end
                            PH_HDR_C:
                            begin
                                if (c == CH_COLON)
                                begin
                                    phase_next = PH_F1_WS;
                                    neg_next   = 1'b0;
                                    mag_next   = '0;
                                end
                                else
                                begin
                                    ended_next = 1'b1;
                                end
                            end
                            PH_F1_WS, PH_F2_WS:
                            begin
                                if ((phase_reg == PH_F1_WS) && (c == CH_COMMA))
                                begin
                                    first_next = field_val;
                                    neg_next   = 1'b0;
                                    mag_next   = '0;
                                    phase_next = PH_F2_WS;
                                end
                                else if (is_blank)
                                begin
                                    // Leading whitespace is skipped.
                                end
                                else if ((c == CH_PLUS) || (c == CH_MINUS))
                                begin
                                    neg_next   = (c == CH_MINUS);
                                    phase_next = (phase_reg == PH_F1_WS) ? PH_F1_DIG
                                                                         : PH_F2_DIG;
                                end
                                else if (is_digit)
                                begin
                                    mag_next   = mag_digit;
                                    phase_next = (phase_reg == PH_F1_WS) ? PH_F1_DIG
                                                                         : PH_F2_DIG;
                                end
                                else if (phase_reg == PH_F1_WS)
                                begin
                                    phase_next = PH_F1_DONE;
                                end
                                else
                                begin
                                    ended_next = 1'b1;
                                end
                            end
                            PH_F1_DIG:
                            begin
                                if (c == CH_COMMA)
                                begin
                                    first_next = field_val;
                                    neg_next   = 1'b0;
                                    mag_next   = '0;
                                    phase_next = PH_F2_WS;
                                end
                                else if (is_digit)
                                    mag_next   = mag_digit;
                                else
                                    phase_next = PH_F1_DONE;
                            end
                            PH_F1_DONE:
                            begin
                                // Only the comma still matters after the first field.
                                if (c == CH_COMMA)
                                begin
                                    first_next = field_val;
                                    neg_next   = 1'b0;
                                    mag_next   = '0;
                                    phase_next = PH_F2_WS;
                                end
                            end
                            PH_F2_DIG:
                            begin
                                if (is_digit)
                                    mag_next   = mag_digit;
                                else
                                    ended_next = 1'b1;
                            end
                            default:
                            begin
                                ended_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
        end
        else if (push)
        begin
            // Read access: report the flag as it was, then clear it.
            fresh_next = 1'b0;
        end

        res.pixel_error = err_next;
        res.green_code  = code_next;
        res.data_fresh  = (s_tuser == OP_READ) ? fresh_reg : fresh_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= PH_HDR_V;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            first_reg <= '0;
            ended_reg <= 1'b0;
            err_reg   <= '0;
            code_reg  <= '0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            first_reg <= first_next;
            ended_reg <= ended_next;
            err_reg   <= err_next;
            code_reg  <= code_next;
            fresh_reg <= fresh_next;
        end
    end

    // Output register with one skid slot. The skid slot fills only when a beat
    // arrives while the output register holds a stalled beat; input is then held off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.green_code, out_reg.pixel_error};
    assign m_tuser  = {out_reg.line_accepted, out_reg.data_fresh};

endmodule

### sv/avld_checker.sv
module avld_checker
    import avld_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0] m_tuser
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // Input is held off only while a result is waiting on the master side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // A line that was just accepted always reports the fresh flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("accepted line without fresh flag");

    // After an accepted input beat, a result beat is always offered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input beat produced no result");

endmodule

bind ascii_vision_line_decoder_top avld_checker u_avld_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/sv/ascii_vision_line_decoder_top_test.sv
`timescale 1ns / 100ps

// Testbench for the line decoder. Bytes and read accesses are sent as beats on
// the slave side. A local decoder model predicts one result beat for every
// accepted input beat and queues it. A checker compares every beat taken on
// the master side with the oldest queued prediction, field by field.
module ascii_vision_line_decoder_top_test;

    import avld_pkg::*;

    // The slowest correct run is far below this bound: every beat can wait out
    // both idle bursts plus the long output hold.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 5000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'h00;    // [7:0] rx_byte
    logic               s_tuser = OP_BYTE;  // [0] opcode

    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;            // [15:0] pixel_error, [31:16] green_code
    logic [TUSER_W-1:0] m_tuser;            // [0] data_fresh, [1] line_accepted

    // Idle bursts on both sides are switched off for the last part of the run.
    logic               idle_bursts = 1'b1;

    // The test sequence asks for a long output hold by bumping hold_seq; the
    // receiver process notices the change and counts the hold down itself.
    int                 hold_seq = 0;
    int                 hold_len = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    int                 ready_gap = 0;

    int                 cycle_count = 0;
    int                 items_sent = 0;
    int                 fail_count = 0;

    // Predicted result beats, oldest first.
    result_t            expected_results[$];

    // Bytes of the line that is about to be sent.
    logic [7:0]         line_buf[$];

    // Decoder model state. It starts at its reset values; reset happens once.
    int                 line_len = 0;
    phase_t             phase = PH_HDR_V;
    logic               neg_field = 1'b0;
    int unsigned        mag_acc = 0;
    logic [VAL_W-1:0]   first_val = '0;
    logic               text_done = 1'b0;
    logic [VAL_W-1:0]   err_val = '0;
    logic [VAL_W-1:0]   code_val = '0;
    logic               fresh = 1'b0;

    ascii_vision_line_decoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF ||
               c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Signed value of the field read so far. The magnitude never exceeds
    // 32768, so only the positive side needs clamping here.
    function automatic logic [VAL_W-1:0] field_value_now();
        if (neg_field)
            return VAL_W'(32'h10000 - mag_acc);
        return (mag_acc > 32767) ? VAL_W'(32767) : VAL_W'(mag_acc);
    endfunction

    function automatic void clear_field();
        neg_field = 1'b0;
        mag_acc   = 0;
    endfunction

    function automatic void add_digit(logic [7:0] c);
        int unsigned m;
        m = mag_acc * 10 + (c - CH_ZERO);
        mag_acc = (m > 32768) ? 32768 : m;
    endfunction

    function automatic void clear_line();
        line_len  = 0;
        phase     = PH_HDR_V;
        text_done = 1'b0;
        clear_field();
    endfunction

    // One character that fits inside the line capacity.
    function automatic void parse_char(logic [7:0] c);
        phase_t ph;
        ph = phase;
        if (text_done)
            return;
        if (c == CH_NUL)
        begin
            text_done = 1'b1;
            return;
        end
        if (ph == PH_HDR_V)
        begin
            if (c == CH_V)
                phase = PH_HDR_C;
            else
                text_done = 1'b1;
            return;
        end
        if (ph == PH_HDR_C)
        begin
            if (c == CH_COLON)
            begin
                phase = PH_F1_WS;
                clear_field();
            end
            else
                text_done = 1'b1;
            return;
        end
        // The first comma closes the first field wherever it stands.
        if ((ph inside {PH_F1_WS, PH_F1_DIG, PH_F1_DONE}) && c == CH_COMMA)
        begin
            first_val = field_value_now();
            clear_field();
            phase = PH_F2_WS;
            return;
        end
        if (ph == PH_F1_DONE)
            return;
        if (ph == PH_F1_WS || ph == PH_F2_WS)
        begin
            if (is_blank(c))
                return;
            if (c == CH_PLUS || c == CH_MINUS || is_digit(c))
            begin
                if (is_digit(c))
                    add_digit(c);
                else
                    neg_field = (c == CH_MINUS);
                if (ph == PH_F1_WS)
                    phase = PH_F1_DIG;
                else
                    phase = PH_F2_DIG;
                return;
            end
        end
        else if (is_digit(c))
        begin
            add_digit(c);
            return;
        end
        // Any other character ends the field being read.
        if (ph == PH_F1_WS || ph == PH_F1_DIG)
            phase = PH_F1_DONE;
        else
            text_done = 1'b1;
    endfunction

    // Advances the model by one accepted beat and returns the result it causes.
    function automatic result_t decode_beat(logic op, logic [7:0] c);
        result_t r;
        logic    fresh_out;
        logic    ended_line;
        ended_line = 1'b0;
        if (op == OP_READ)
        begin
            fresh_out = fresh;
            fresh     = 1'b0;
        end
        else
        begin
            if (c == CH_LF || c == CH_CR)
            begin
                // An empty line is skipped without touching anything.
                if (line_len > 0)
                begin
                    if (phase == PH_F2_WS || phase == PH_F2_DIG)
                    begin
                        err_val    = first_val;
                        code_val   = field_value_now();
                        fresh      = 1'b1;
                        ended_line = 1'b1;
                    end
                    clear_line();
                end
            end
            else if (line_len < LINE_CAPACITY - 1)
            begin
                parse_char(c);
                line_len++;
            end
            fresh_out = fresh;
        end
        r.pixel_error   = err_val;
        r.green_code    = code_val;
        r.data_fresh    = fresh_out;
        r.line_accepted = ended_line;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Line builders
    // ------------------------------------------------------------------

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void push_blanks(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: line_buf.push_back(CH_TAB);
                1: line_buf.push_back(CH_VT);
                2: line_buf.push_back(CH_FF);
                default: line_buf.push_back(CH_SPACE);
            endcase
        end
    endfunction

    // A field as atoi sees it: optional blanks, optional sign, digits (none in some fields).
    function automatic void push_field();
        int unsigned kind;
        int unsigned mag;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            push_blanks($urandom_range(1, 3));
        case ($urandom_range(0, 3))
            1, 3: line_buf.push_back(CH_MINUS);
            2: line_buf.push_back(CH_PLUS);
            default: ;
        endcase
        case (kind)
            0: ;  // no digits at all, so the field reads as zero
            1:
            begin
                case ($urandom_range(0, 4))
                    0: mag = 32767;
                    1: mag = 32768;
                    2: mag = 32769;
                    3: mag = 99999;
                    default: mag = 0;
                endcase
                push_text($sformatf("%0d", mag));
            end
            2: push_text($sformatf("%0d", $urandom_range(100000, 32'hFFFF_FFFF)));
            3: push_text($sformatf("000%0d", $urandom_range(0, 99)));
            default: push_text($sformatf("%0d", $urandom_range(0, (kind < 6) ? 999 : 40000)));
        endcase
    endfunction

    function automatic void push_line_end();
        case ($urandom_range(0, 3))
            0: line_buf.push_back(CH_CR);
            1: line_buf.push_back(CH_LF);
            2:
            begin
                line_buf.push_back(CH_CR);
                line_buf.push_back(CH_LF);
            end
            default:
            begin
                line_buf.push_back(CH_LF);
                line_buf.push_back(CH_LF);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one beat, holding it until the slave side takes it, and feeds the
    // model at the edge of acceptance. The task is entered just after a rising
    // edge, so every drive below is a single nonblocking update for that step.
    task automatic send_beat(input logic op, input logic [7:0] data);
        if (idle_bursts && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(decode_beat(op, data));
        items_sent++;
    endtask

    // Sends the buffered line; with mix_reads set, read accesses are slipped
    // in between bytes at random.
    task automatic send_line_buf(input logic mix_reads);
        foreach (line_buf[i])
        begin
            if (mix_reads && $urandom_range(0, 11) == 0)
                send_beat(OP_READ, 8'($urandom));
            send_beat(OP_BYTE, line_buf[i]);
        end
        line_buf.delete();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready bursts plus the long hold on request.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (ready_gap > 0)
        begin
            ready_gap <= ready_gap - 1;
            m_tready  <= 1'b0;
        end
        else if (idle_bursts && $urandom_range(0, 4) == 0)
        begin
            ready_gap <= $urandom_range(0, 6);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'({m_tuser, m_tdata});
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: pixel_error %0d green_code %0d",
                       $signed(got.pixel_error), $signed(got.green_code));
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.pixel_error !== want.pixel_error)
                begin
                    $error("pixel_error: expected %0d, actual %0d",
                           $signed(want.pixel_error), $signed(got.pixel_error));
                    fail_count++;
                end
                if (got.green_code !== want.green_code)
                begin
                    $error("green_code: expected %0d, actual %0d",
                           $signed(want.green_code), $signed(got.green_code));
                    fail_count++;
                end
                if (got.data_fresh !== want.data_fresh)
                begin
                    $error("data_fresh: expected %0b, actual %0b",
                           want.data_fresh, got.data_fresh);
                    fail_count++;
                end
                if (got.line_accepted !== want.line_accepted)
                begin
                    $error("line_accepted: expected %0b, actual %0b",
                           want.line_accepted, got.line_accepted);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A handful of hand-made lines: a negative overflow after a tab, a plus
    // sign, a second field cut short by a letter, a read that clears the
    // flag, an empty line, a line holding only a NUL, and two empty fields.
    task automatic test_directed();
        push_text("V:\t-99999,+7x9");
        line_buf.push_back(CH_CR);
        send_line_buf(1'b0);
        send_beat(OP_READ, 8'hFF);
        line_buf.push_back(CH_LF);
        line_buf.push_back(CH_NUL);
        line_buf.push_back(CH_LF);
        push_text("V:,");
        line_buf.push_back(CH_LF);
        send_line_buf(1'b0);
        send_beat(OP_READ, 8'h00);
    endtask

    // Mostly well-formed lines with random fields; the rest are long lines,
    // missing commas, bad headers, corrupted bytes, embedded NULs, noise and
    // empty lines.
    task automatic test_random_lines(input int n_items);
        int stop_at;
        int k;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            k = $urandom_range(0, 99);
            if (k < 8)
            begin
                repeat ($urandom_range(1, 12))
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            else if (k < 12)
                ;  // just a line end
            else if (k < 18)
            begin
                if (k < 15)
                    line_buf.push_back(CH_V);
                line_buf.push_back(8'($urandom_range(0, 255)));
                push_text(":12,34");
            end
            else
            begin
                push_text("V:");
                // Long lines push the comma or the fields past the capacity.
                if (k < 25)
                    push_blanks($urandom_range(50, 70));
                push_field();
                if (!(k >= 25 && k < 31))
                begin
                    line_buf.push_back(CH_COMMA);
                    push_field();
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4))
                        line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
                if (k >= 31 && k < 41)
                    line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
                else if (k >= 41 && k < 47)
                    line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
            end
            push_line_end();
            send_line_buf(1'b1);
        end
    endtask

    // The receiver holds off for a long stretch while lines keep coming, so
    // both result slots fill and the slave side must stall.
    task automatic test_output_stall();
        hold_len <= 160;
        hold_seq <= hold_seq + 1;
        test_random_lines(60);
    endtask

    // The final stretch runs with no idling on either side.
    task automatic test_full_rate();
        idle_bursts <= 1'b0;
        test_random_lines(260);
    endtask

    initial
    begin
        int drain;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_lines(1500);
        test_output_stall();
        test_full_rate();
        s_tvalid <= 1'b0;

        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected result beats never arrived", expected_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
